// File: rtl/nnis_pkg.sv
// nnis_pkg: shared constants for the nearest-neighbor image scaler.
// Field widths, register indexes, operation codes and parameter defaults.
// No dependencies.
package nnis_pkg;

  localparam int FRAC_BITS = 16;

  localparam int POS_W      = 12;
  localparam int CHAN_W     = 2;
  localparam int SAMPLE_W   = 8;
  localparam int SRC_REG_W  = 9;
  localparam int DST_REG_W  = 13;
  localparam int WIN_REG_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int DEF_MAX_SRC_WIDTH  = 256;
  localparam int DEF_MAX_SRC_HEIGHT = 256;
  localparam int DEF_MAX_CHANNELS   = 4;
  localparam int DEF_MAX_WINDOW     = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 3'd4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// File: rtl/nnis_ram.sv
// nnis_ram: generic single-port RAM with registered read data.
// Used as the frame store; no dependencies.
module nnis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/nnis_div.sv
// nnis_div: restoring divider, one quotient bit per cycle.
// Computes the 9.16 scale ratios (default source size); no dependencies.
module nnis_div #(
  parameter int NW = 25,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);

  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  logic          run;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [NW-1:0] q;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, q[NW-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q     <= num;
      rem   <= '0;
      den_r <= den;
    end else if (run) begin
      rem <= fits ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      q   <= {q[NW-2:0], fits};
    end
  end

endmodule

// File: rtl/nnis_mul.sv
// nnis_mul: two-lane multiplier with registered products.
// Maps positions in the setup phase and squares offsets during the search.
module nnis_mul #(
  parameter int AW = 20,
  parameter int BW = 25
) (
  input  logic             clk,
  input  logic [AW-1:0]    a_x,
  input  logic [BW-1:0]    b_x,
  input  logic [AW-1:0]    a_y,
  input  logic [BW-1:0]    b_y,
  output logic [AW+BW-1:0] p_x,
  output logic [AW+BW-1:0] p_y
);

  always_ff @(posedge clk) begin
    p_x <= (AW+BW)'(a_x) * (AW+BW)'(b_x);
    p_y <= (AW+BW)'(a_y) * (AW+BW)'(b_y);
  end

endmodule

// File: rtl/nearest_neighbour_image_scaler.sv
// nearest_neighbour_image_scaler: frame store plus nearest-neighbor resize sequencer.
// Uses nnis_pkg, nnis_ram (frame store), nnis_div (ratios), nnis_mul (shared multiplier).
//
// channel   direction  signals                                   transaction
// command   in         start/busy, operation pos_x pos_y ...     start & !busy
// result    out        done, sample_out                          done (one cycle)
// config    in         cfg_valid/cfg_ready, cfg_index cfg_data   cfg_valid & cfg_ready
//
// Load: busy stays low. Query: the search reads (2*(window_size/2)+1)^2 candidates,
// one per cycle through the frame-store read port; the first query after a config
// write first runs the divider for both ratios.
// Query with an absent channel: result the cycle after the transaction.
// Synchronous reset restores register defaults; the frame store is not cleared.
// Results cannot be stalled; done marks each one for a single cycle.
module nearest_neighbour_image_scaler #(
  parameter int MAX_SRC_WIDTH  = nnis_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = nnis_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int MAX_CHANNELS   = nnis_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_WINDOW     = nnis_pkg::DEF_MAX_WINDOW
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation,
  input  logic [nnis_pkg::POS_W-1:0]        pos_x,
  input  logic [nnis_pkg::POS_W-1:0]        pos_y,
  input  logic [nnis_pkg::CHAN_W-1:0]       channel,
  input  logic [nnis_pkg::SAMPLE_W-1:0]     sample_in,
  output logic                              done,
  output logic [nnis_pkg::SAMPLE_W-1:0]     sample_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int FRAC  = nnis_pkg::FRAC_BITS;
  localparam int PW    = nnis_pkg::POS_W;
  localparam int SW    = nnis_pkg::SAMPLE_W;
  localparam int DRW   = nnis_pkg::DST_REG_W;
  localparam int EWX   = $clog2(MAX_SRC_WIDTH + 1);
  localparam int EWY   = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int PXW   = EWX + FRAC;
  localparam int PYW   = EWY + FRAC;
  localparam int RWM   = (PXW > PYW) ? PXW : PYW;
  localparam int RMAX  = MAX_WINDOW / 2;
  localparam int RB    = (RMAX < 1) ? 1 : $clog2(RMAX + 1);
  localparam int DXW   = FRAC + $clog2(RMAX + 2) + 1;
  localparam int SQW   = 2 * DXW;
  localparam int MAW   = (PW > DXW) ? PW : DXW;
  localparam int MBW   = (RWM > DXW) ? RWM : DXW;
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT * MAX_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV    = 6'b000010,
    S_MAP    = 6'b000100,
    S_ROUND  = 6'b001000,
    S_SEARCH = 6'b010000,
    S_DRAIN  = 6'b100000
  } state_t;

  state_t state;

  logic [nnis_pkg::SRC_REG_W-1:0] src_w;
  logic [nnis_pkg::SRC_REG_W-1:0] src_h;
  logic [DRW-1:0]                 dst_w;
  logic [DRW-1:0]                 dst_h;
  logic [nnis_pkg::WIN_REG_W-1:0] win;

  logic [EWX-1:0] sw_eff;
  logic [EWY-1:0] sh_eff;
  logic [DRW-1:0] dw_eff;
  logic [DRW-1:0] dh_eff;
  logic [3:0]     win_eff;

  logic accept;
  logic load_we;

  logic [PW-1:0]  q_x;
  logic [PW-1:0]  q_y;
  logic [nnis_pkg::CHAN_W-1:0] q_ch;

  logic           ratio_ok;
  logic           div_go;
  logic           div_phase;
  logic           div_done;
  logic [RWM-1:0] div_num;
  logic [DRW-1:0] div_den;
  logic [RWM-1:0] div_quo;
  logic [RWM-1:0] ratio_x;
  logic [RWM-1:0] ratio_y;

  logic [MAW-1:0]     mul_ax;
  logic [MBW-1:0]     mul_bx;
  logic [MAW-1:0]     mul_ay;
  logic [MBW-1:0]     mul_by;
  logic [MAW+MBW-1:0] prod_x;
  logic [MAW+MBW-1:0] prod_y;

  logic [PXW-1:0] px;
  logic [PYW-1:0] py;
  logic [PXW:0]   rnd_x;
  logic [PYW:0]   rnd_y;
  logic [EWX-1:0] nx;
  logic [EWY-1:0] ny;
  logic [RB-1:0]  rad;
  logic signed [RB:0] rs;
  logic signed [RB:0] oi;
  logic signed [RB:0] oj;
  logic           last_cand;

  logic signed [EWX+1:0] sx;
  logic signed [EWY+1:0] sy;
  logic [EWX-1:0] cx;
  logic [EWY-1:0] cy;
  logic [PXW-1:0] cxf;
  logic [PYW-1:0] cyf;

  logic           a_v;
  logic           a_last;
  logic [DXW-1:0] dx_a;
  logic [DXW-1:0] dy_a;
  logic           b_v;
  logic           b_last;
  logic [SW-1:0]  samp_b;
  logic [SQW:0]   sq_dist;
  logic           take;
  logic           first;
  logic [SQW:0]   best_d;
  logic [SW-1:0]  best;

  logic [AW-1:0]  ram_addr;
  logic [SW-1:0]  ram_rdata;

  function automatic logic [AW-1:0] store_addr(input logic [15:0] x, input logic [15:0] y,
                                               input logic [nnis_pkg::CHAN_W-1:0] c);
    return AW'((32'(y) * MAX_SRC_WIDTH + 32'(x)) * MAX_CHANNELS + 32'(c));
  endfunction

  // effective register values
  always_comb begin
    if (src_w == '0) begin
      sw_eff = EWX'(1);
    end else if (32'(src_w) > MAX_SRC_WIDTH) begin
      sw_eff = EWX'(MAX_SRC_WIDTH);
    end else begin
      sw_eff = EWX'(src_w);
    end
    if (src_h == '0) begin
      sh_eff = EWY'(1);
    end else if (32'(src_h) > MAX_SRC_HEIGHT) begin
      sh_eff = EWY'(MAX_SRC_HEIGHT);
    end else begin
      sh_eff = EWY'(src_h);
    end
    dw_eff  = (dst_w == '0) ? DRW'(1) : dst_w;
    dh_eff  = (dst_h == '0) ? DRW'(1) : dst_h;
    win_eff = (32'(win) > MAX_WINDOW) ? 4'(MAX_WINDOW) : 4'(win);
  end

  // no config write in the cycle a command is offered
  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign accept    = start && !busy;
  assign load_we   = accept && (operation == nnis_pkg::OP_LOAD) &&
                     (32'(pos_x) < 32'(sw_eff)) && (32'(pos_y) < 32'(sh_eff)) &&
                     (32'(channel) < MAX_CHANNELS);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= nnis_pkg::SRC_REG_W'(256);
      src_h <= nnis_pkg::SRC_REG_W'(256);
      dst_w <= DRW'(256);
      dst_h <= DRW'(256);
      win   <= nnis_pkg::WIN_REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nnis_pkg::CFG_SRC_WIDTH:   src_w <= cfg_data[nnis_pkg::SRC_REG_W-1:0];
        nnis_pkg::CFG_SRC_HEIGHT:  src_h <= cfg_data[nnis_pkg::SRC_REG_W-1:0];
        nnis_pkg::CFG_DST_WIDTH:   dst_w <= cfg_data[DRW-1:0];
        nnis_pkg::CFG_DST_HEIGHT:  dst_h <= cfg_data[DRW-1:0];
        nnis_pkg::CFG_WINDOW_SIZE: win   <= cfg_data[nnis_pkg::WIN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // ratio divider
  assign div_num = div_phase ? RWM'({sh_eff, {FRAC{1'b0}}}) : RWM'({sw_eff, {FRAC{1'b0}}});
  assign div_den = div_phase ? dh_eff : dw_eff;

  nnis_div #(
    .NW (RWM),
    .DW (DRW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .done (div_done)
  );

  // shared multiplier: position mapping, then squared offsets
  always_comb begin
    if (state == S_MAP) begin
      mul_ax = MAW'(q_x);
      mul_bx = MBW'(ratio_x);
      mul_ay = MAW'(q_y);
      mul_by = MBW'(ratio_y);
    end else begin
      mul_ax = MAW'(dx_a);
      mul_bx = MBW'(dx_a);
      mul_ay = MAW'(dy_a);
      mul_by = MBW'(dy_a);
    end
  end

  nnis_mul #(
    .AW (MAW),
    .BW (MBW)
  ) u_mul (
    .clk (clk),
    .a_x (mul_ax),
    .b_x (mul_bx),
    .a_y (mul_ay),
    .b_y (mul_by),
    .p_x (prod_x),
    .p_y (prod_y)
  );

  // rounding of the mapped position
  assign rnd_x = (PXW+1)'(prod_x[PXW-1:0]) + (PXW+1)'(1 << (FRAC - 1));
  assign rnd_y = (PYW+1)'(prod_y[PYW-1:0]) + (PYW+1)'(1 << (FRAC - 1));

  // candidate position and distance components
  assign rs = $signed({1'b0, rad});
  assign sx = $signed({2'b00, nx}) + (EWX+2)'(oi);
  assign sy = $signed({2'b00, ny}) + (EWY+2)'(oj);

  always_comb begin
    if (sx < 0) begin
      cx = '0;
    end else if (sx > $signed({2'b00, sw_eff - 1'b1})) begin
      cx = sw_eff - 1'b1;
    end else begin
      cx = sx[EWX-1:0];
    end
    if (sy < 0) begin
      cy = '0;
    end else if (sy > $signed({2'b00, sh_eff - 1'b1})) begin
      cy = sh_eff - 1'b1;
    end else begin
      cy = sy[EWY-1:0];
    end
  end

  assign cxf       = {cx, {FRAC{1'b0}}};
  assign cyf       = {cy, {FRAC{1'b0}}};
  assign last_cand = (oi == rs) && (oj == rs);

  // frame store
  assign ram_addr = (state == S_SEARCH) ? store_addr(16'(cx), 16'(cy), q_ch)
                                        : store_addr(16'(pos_x), 16'(pos_y), channel);

  nnis_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (load_we),
    .addr  (ram_addr),
    .wdata (sample_in),
    .rdata (ram_rdata)
  );

  // best-candidate compare
  assign sq_dist = (SQW+1)'(prod_x[SQW-1:0]) + (SQW+1)'(prod_y[SQW-1:0]);
  assign take    = b_v && (first || (sq_dist < best_d));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ratio_ok  <= 1'b0;
      div_go    <= 1'b0;
      div_phase <= 1'b0;
      done      <= 1'b0;
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      a_last    <= 1'b0;
      b_last    <= 1'b0;
      first     <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      a_v    <= 1'b0;
      a_last <= 1'b0;
      b_v    <= a_v;
      b_last <= a_last;
      if (cfg_valid && cfg_ready) begin
        ratio_ok <= 1'b0;
      end
      if (take) begin
        first <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (operation == nnis_pkg::OP_QUERY)) begin
            if (32'(channel) >= MAX_CHANNELS) begin
              done <= 1'b1;
            end else if (ratio_ok) begin
              state <= S_MAP;
            end else begin
              state     <= S_DIV;
              div_go    <= 1'b1;
              div_phase <= 1'b0;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!div_phase) begin
              div_phase <= 1'b1;
              div_go    <= 1'b1;
            end else begin
              ratio_ok <= 1'b1;
              state    <= S_MAP;
            end
          end
        end
        S_MAP: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          first <= 1'b1;
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          a_v    <= 1'b1;
          a_last <= last_cand;
          if (last_cand) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (b_v && b_last) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      q_x  <= (32'(pos_x) >= 32'(dw_eff)) ? PW'(dw_eff - 1'b1) : pos_x;
      q_y  <= (32'(pos_y) >= 32'(dh_eff)) ? PW'(dh_eff - 1'b1) : pos_y;
      q_ch <= channel;
    end
    if (state == S_DIV && div_done) begin
      if (!div_phase) begin
        ratio_x <= div_quo;
      end else begin
        ratio_y <= div_quo;
      end
    end
    if (state == S_ROUND) begin
      px  <= prod_x[PXW-1:0];
      py  <= prod_y[PYW-1:0];
      nx  <= (rnd_x[PXW:FRAC] > (EWX+1)'(sw_eff - 1'b1)) ? sw_eff - 1'b1
                                                          : rnd_x[FRAC+EWX-1:FRAC];
      ny  <= (rnd_y[PYW:FRAC] > (EWY+1)'(sh_eff - 1'b1)) ? sh_eff - 1'b1
                                                          : rnd_y[FRAC+EWY-1:FRAC];
      rad <= RB'(win_eff >> 1);
      oi  <= -$signed({1'b0, RB'(win_eff >> 1)});
      oj  <= -$signed({1'b0, RB'(win_eff >> 1)});
    end
    if (state == S_SEARCH) begin
      dx_a <= DXW'((cxf >= px) ? cxf - px : px - cxf);
      dy_a <= DXW'((cyf >= py) ? cyf - py : py - cyf);
      if (oj == rs) begin
        oj <= -rs;
        oi <= oi + 1'b1;
      end else begin
        oj <= oj + 1'b1;
      end
    end
    samp_b <= ram_rdata;
    if (take) begin
      best_d <= sq_dist;
      best   <= samp_b;
    end
    if (accept && (operation == nnis_pkg::OP_QUERY) && (32'(channel) >= MAX_CHANNELS)) begin
      sample_out <= '0;
    end else if (state == S_DRAIN && b_v && b_last) begin
      sample_out <= take ? samp_b : best;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while a query is still in progress");

  a_we_idle: assert property (@(posedge clk) disable iff (rst)
    load_we |-> (state == S_IDLE))
    else $error("frame store written during a query");

  a_cfg_clears_ratio: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !ratio_ok)
    else $error("ratio kept valid across a config write");

  a_search_ratio: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> ratio_ok)
    else $error("search started without valid ratios");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> ((oi <= rs) && (oi >= -rs) && (oj <= rs) && (oj >= -rs)))
    else $error("window offset outside the search radius");
`endif

endmodule
